>>> rtl/morse_enc_pkg.sv
// Package with the element codes, the lookup record type and the Morse code table.
`timescale 1ns / 1ps

package morse_enc_pkg;

   // Element codes on the result channel.
   localparam logic [1:0] ELEM_DIT = 2'd0;
   localparam logic [1:0] ELEM_DAH = 2'd1;
   localparam logic [1:0] ELEM_GAP = 2'd2;

   // Longest pattern and the widths that follow from it.
   localparam int MaxElems = 6;
   localparam int CntWidth = $clog2(MaxElems + 1);

   // Characters with special handling.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;

   // One looked-up pattern. Bits are left aligned: bit 5 is the first element,
   // 1 means dah and 0 means dit. A gap pattern is a single medium gap.
   typedef struct packed {
      logic [CntWidth-1:0] len;
      logic [MaxElems-1:0] bits;
      logic                gap;
   } pattern_type;

   // True for the punctuation marks that produce a medium gap or a long pattern.
   function automatic logic is_symbol(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_BANG) ||
             (c == CHAR_DOT) || (c == CHAR_QUERY);
   endfunction

   // Fold lower case to upper case.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h61:8'h7A]}) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   // Letter table, indexed by the letter's place in the alphabet.
   function automatic pattern_type letter_pattern(input logic [4:0] idx);
      pattern_type p;
      p.gap = 1'b0;
      case (idx)
         5'd0:    begin p.len = 3'd2; p.bits = 6'b010000; end
         5'd1:    begin p.len = 3'd4; p.bits = 6'b100000; end
         5'd2:    begin p.len = 3'd4; p.bits = 6'b101000; end
         5'd3:    begin p.len = 3'd3; p.bits = 6'b100000; end
         5'd4:    begin p.len = 3'd1; p.bits = 6'b000000; end
         5'd5:    begin p.len = 3'd4; p.bits = 6'b001000; end
         5'd6:    begin p.len = 3'd3; p.bits = 6'b110000; end
         5'd7:    begin p.len = 3'd4; p.bits = 6'b000000; end
         5'd8:    begin p.len = 3'd2; p.bits = 6'b000000; end
         5'd9:    begin p.len = 3'd4; p.bits = 6'b011100; end
         5'd10:   begin p.len = 3'd3; p.bits = 6'b101000; end
         5'd11:   begin p.len = 3'd4; p.bits = 6'b010000; end
         5'd12:   begin p.len = 3'd2; p.bits = 6'b110000; end
         5'd13:   begin p.len = 3'd2; p.bits = 6'b100000; end
         5'd14:   begin p.len = 3'd3; p.bits = 6'b111000; end
         5'd15:   begin p.len = 3'd4; p.bits = 6'b011000; end
         5'd16:   begin p.len = 3'd4; p.bits = 6'b110100; end
         5'd17:   begin p.len = 3'd3; p.bits = 6'b010000; end
         5'd18:   begin p.len = 3'd3; p.bits = 6'b000000; end
         5'd19:   begin p.len = 3'd1; p.bits = 6'b100000; end
         5'd20:   begin p.len = 3'd3; p.bits = 6'b001000; end
         5'd21:   begin p.len = 3'd4; p.bits = 6'b000100; end
         5'd22:   begin p.len = 3'd3; p.bits = 6'b011000; end
         5'd23:   begin p.len = 3'd4; p.bits = 6'b100100; end
         5'd24:   begin p.len = 3'd4; p.bits = 6'b101100; end
         5'd25:   begin p.len = 3'd4; p.bits = 6'b110000; end
         default: begin p.len = 3'd0; p.bits = 6'b000000; end
      endcase
      return p;
   endfunction

   // Digit table: every digit is five elements long.
   function automatic pattern_type digit_pattern(input logic [3:0] idx);
      pattern_type p;
      p.gap = 1'b0;
      p.len = 3'd5;
      case (idx)
         4'd0:    p.bits = 6'b111110;
         4'd1:    p.bits = 6'b011110;
         4'd2:    p.bits = 6'b001110;
         4'd3:    p.bits = 6'b000110;
         4'd4:    p.bits = 6'b000010;
         4'd5:    p.bits = 6'b000000;
         4'd6:    p.bits = 6'b100000;
         4'd7:    p.bits = 6'b110000;
         4'd8:    p.bits = 6'b111000;
         4'd9:    p.bits = 6'b111100;
         default: begin p.len = 3'd0; p.bits = 6'b000000; end
      endcase
      return p;
   endfunction

   // Full lookup of one character, given whether the previous one was punctuation.
   function automatic pattern_type lookup(input logic [7:0] code, input logic prev_sym);
      pattern_type p;
      logic [7:0]  c;
      logic [7:0]  off;
      c = fold_case(code);
      p.len = '0;
      p.bits = '0;
      p.gap = 1'b0;
      if (c inside {[8'h41:8'h5A]}) begin
         off = c - 8'h41;
         p = letter_pattern(off[4:0]);
      end else if (c inside {[8'h30:8'h39]}) begin
         off = c - 8'h30;
         p = digit_pattern(off[3:0]);
      end else if (is_symbol(c) && !prev_sym) begin
         if (c == CHAR_QUERY) begin
            p.len = 3'd6;
            p.bits = 6'b001100;
         end else if (c == CHAR_DOT) begin
            p.len = 3'd6;
            p.bits = 6'b010101;
         end else begin
            p.len = 3'd1;
            p.gap = 1'b1;
         end
      end
      return p;
   endfunction

endpackage

>>> rtl/morse_character_encoder.sv
// Morse character encoder: one character in, its dit, dah and gap elements out.
`timescale 1ns / 1ps
// The first element is offered in the cycle after the character transfer.
// One element per cycle while the result side is ready, through one shift register
// and a down counter; no new character is taken until the last element of the
// current one is accepted, and a character that yields nothing leaves the block ready.
// Reset clears the sequencer and the punctuation flag; the block is ready next cycle.

module morse_character_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] element, [7:2] zero
   output logic       rsp_tlast    // last
);
   import morse_enc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                state_ff, state_in;
   logic                prev_sym_ff, prev_sym_in;
   logic [MaxElems-1:0] bits_ff, bits_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                gap_ff, gap_in;
   pattern_type         pat;
   logic                req_xfer;
   logic                rsp_xfer;
   logic [1:0]          element;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // Table lookup of the incoming character.
   assign pat = lookup(req_tdata, prev_sym_ff);

   // Current element comes from the top of the shift register.
   always_comb begin
      if (gap_ff) begin
         element = ELEM_GAP;
      end else if (bits_ff[MaxElems-1]) begin
         element = ELEM_DAH;
      end else begin
         element = ELEM_DIT;
      end
   end

   assign rsp_tdata = {6'd0, element};
   assign rsp_tlast = (cnt_ff == CntWidth'(1));

   // Sequencer: load a pattern on a request transfer, shift one element per result transfer.
   always_comb begin
      state_in    = state_ff;
      prev_sym_in = prev_sym_ff;
      bits_in     = bits_ff;
      cnt_in      = cnt_ff;
      gap_in      = gap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               prev_sym_in = is_symbol(fold_case(req_tdata));
               bits_in     = pat.bits;
               cnt_in      = pat.len;
               gap_in      = pat.gap;
               if (pat.len != '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               bits_in = {bits_ff[MaxElems-2:0], 1'b0};
               cnt_in  = cnt_ff - CntWidth'(1);
               if (cnt_ff == CntWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prev_sym_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         prev_sym_ff <= prev_sym_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Pattern registers.
   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      gap_ff  <= gap_in;
   end

endmodule

>>> tb/morse_character_encoder_checker.sv
// Checker for the Morse character encoder: predicts each character's elements and compares them.
`timescale 1ns / 1ps

module morse_character_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [1:0] element, [7:2] zero
   input  logic       rsp_tlast,   // last
   output int         error_count,
   output int         elems_pending,
   output int         elems_checked,
   output int         chars_seen
);

   import morse_enc_pkg::*;

   typedef struct packed {
      logic [1:0] element;
      logic       last;
   } element_rec_t;

   // Elements predicted but not yet seen on the result channel, oldest first.
   element_rec_t pending_elements[$];

   // Predictor copy of the punctuation flag.
   logic last_was_punct;

   int errors;
   int checked;
   int chars;
   element_rec_t rec;

   // Work out the elements of one character and queue them; update the flag.
   task automatic predict_elements(input logic [7:0] code);
      logic [7:0]   ch;
      logic         punct;
      string        pat;
      element_rec_t item;
      int           i;
      ch = code;
      if (code >= "a" && code <= "z") begin
         ch = code - 8'd32;
      end
      punct = (ch == CHAR_SPACE) || (ch == CHAR_COMMA) || (ch == CHAR_BANG) ||
              (ch == CHAR_DOT) || (ch == CHAR_QUERY);
      pat = "";
      case (ch)
         "A": pat = ".-";    "B": pat = "-...";  "C": pat = "-.-.";  "D": pat = "-..";
         "E": pat = ".";     "F": pat = "..-.";  "G": pat = "--.";   "H": pat = "....";
         "I": pat = "..";    "J": pat = ".---";  "K": pat = "-.-";   "L": pat = ".-..";
         "M": pat = "--";    "N": pat = "-.";    "O": pat = "---";   "P": pat = ".--.";
         "Q": pat = "--.-";  "R": pat = ".-.";   "S": pat = "...";   "T": pat = "-";
         "U": pat = "..-";   "V": pat = "...-";  "W": pat = ".--";   "X": pat = "-..-";
         "Y": pat = "-.--";  "Z": pat = "--..";
         "0": pat = "-----"; "1": pat = ".----"; "2": pat = "..---"; "3": pat = "...--";
         "4": pat = "....-"; "5": pat = "....."; "6": pat = "-...."; "7": pat = "--...";
         "8": pat = "---.."; "9": pat = "----.";
         default: pat = "";
      endcase
      // Punctuation only sounds when the character before it was not punctuation.
      if (punct && !last_was_punct) begin
         if (ch == CHAR_QUERY) begin
            pat = "..--..";
         end else if (ch == CHAR_DOT) begin
            pat = ".-.-.-";
         end else begin
            pat = "g";
         end
      end
      for (i = 0; i < pat.len(); i++) begin
         case (pat[i])
            "-":     item.element = ELEM_DAH;
            "g":     item.element = ELEM_GAP;
            default: item.element = ELEM_DIT;
         endcase
         item.last = (i == pat.len() - 1);
         pending_elements.push_back(item);
      end
      last_was_punct = punct;
   endtask

   initial begin
      errors = 0;
      checked = 0;
      chars = 0;
      last_was_punct = 1'b0;
      error_count = 0;
      elems_pending = 0;
      elems_checked = 0;
      chars_seen = 0;
   end

   // Results are checked before new characters are predicted, since a
   // character never produces an element in the cycle of its own transfer.
   always @(posedge clock) begin
      if (reset) begin
         last_was_punct = 1'b0;
         pending_elements.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_elements.size() == 0) begin
               errors++;
               $display("%0t: unexpected element transfer: tdata %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               rec = pending_elements.pop_front();
               checked++;
               if (rsp_tdata !== {6'b0, rec.element} || rsp_tlast !== rec.last) begin
                  errors++;
                  $display("%0t: element mismatch: expected tdata %h last %b, got tdata %h last %b",
                           $time, {6'b0, rec.element}, rec.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            chars++;
            predict_elements(req_tdata);
         end
      end
      error_count <= errors;
      elems_pending <= pending_elements.size();
      elems_checked <= checked;
      chars_seen <= chars;
   end

endmodule

>>> tb/morse_character_encoder_tb.sv
// Testbench top for the Morse character encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module morse_character_encoder_tb;

   import morse_enc_pkg::*;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] char_code
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [1:0] element, [7:2] zero
   logic       rsp_tlast;    // last

   int error_count;
   int elems_pending;
   int elems_checked;
   int chars_seen;

   // Idle knobs for the two sides; each random phase sets them differently.
   bit req_idle_on;
   bit rsp_stall_on;

   // Directed characters: byte extremes, table ends, range borders and punctuation runs.
   logic [7:0] directed_chars [26] = '{
      8'h00, 8'hFF, "A", "z", "Q", "0", "9",
      CHAR_QUERY, CHAR_DOT, CHAR_SPACE, CHAR_COMMA, CHAR_BANG,
      "E", CHAR_DOT, 8'h80, CHAR_QUERY, 8'h60, CHAR_SPACE, 8'h7B, CHAR_COMMA,
      "Z", CHAR_BANG, "@", "[", "/", ":"
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   morse_character_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   morse_character_encoder_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .elems_pending (elems_pending),
      .elems_checked (elems_checked),
      .chars_seen    (chars_seen)
   );

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap(input int min_len);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return min_len;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offer one character and hold it until the transfer completes.
   task automatic send_char(input logic [7:0] code);
      int gap;
      gap = req_idle_on ? pick_gap(0) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Result side back-pressure.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap(1)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Stimulus and verdict.
   initial begin
      int phase;
      int n;
      int sel;
      logic [7:0] code;
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      foreach (directed_chars[i]) begin
         send_char(directed_chars[i]);
      end

      // Random text: letters of both cases, digits, punctuation runs and raw bytes.
      for (phase = 0; phase < 4; phase++) begin
         req_idle_on = (phase == 0) || (phase == 2);
         rsp_stall_on = (phase == 0) || (phase == 3);
         for (n = 0; n < 90; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
               code = 8'(32'h41 + $urandom_range(0, 25));
               if ($urandom_range(0, 1) == 1) begin
                  code = code + 8'd32;
               end
            end else if (sel < 55) begin
               code = 8'(32'h30 + $urandom_range(0, 9));
            end else if (sel < 80) begin
               case ($urandom_range(0, 4))
                  0:       code = CHAR_SPACE;
                  1:       code = CHAR_COMMA;
                  2:       code = CHAR_BANG;
                  3:       code = CHAR_DOT;
                  default: code = CHAR_QUERY;
               endcase
            end else begin
               code = 8'($urandom_range(0, 255));
            end
            send_char(code);
         end
      end

      // Drain the remaining elements, then keep watching for strays.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (elems_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d characters and checked %0d Morse elements,", chars_seen,
               elems_checked);
      $display("with letters, digits, punctuation runs and raw bytes under idles and stalls.");
      if (error_count == 0 && elems_pending == 0) begin
         $display("morse_character_encoder_tb: PASS");
      end else begin
         $display("morse_character_encoder_tb: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("Timeout: the run did not complete.");
      $display("morse_character_encoder_tb: FAIL");
      $finish;
   end

endmodule
